FILE: hw/rtl/so3_pkg.sv
// Shared constants, operation codes and arithmetic helpers for the SO(3) map core.
`default_nettype none

package so3_pkg;

   // Fraction bits of the rotation vector components.
   localparam int ANGLE_FRAC_BITS = 14;

   localparam logic [1:0] OP_EXP    = 2'd0;
   localparam logic [1:0] OP_GAMMA1 = 2'd1;
   localparam logic [1:0] OP_GAMMA2 = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [35:0]        HALF_PI_Q30     = 36'd1686629713;
   localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sd652032874;
   localparam logic signed [35:0] ONE_Q30         = 36'sd1073741824;
   localparam logic signed [39:0] COEF_LIMIT      = 40'sd2147483648;
   localparam logic signed [39:0] COEF_HALF       = 40'sd536870912;
   localparam logic signed [65:0] DIAG_ONE_Q60    = 66'sd1152921504606846976;
   localparam logic signed [65:0] DIAG_HALF_Q60   = 66'sd576460752303423488;
   localparam logic signed [65:0] ROUND_Q44       = 66'sd8796093022208;
   localparam logic signed [65:0] OUT_MAX         = 66'sd262143;
   localparam logic signed [65:0] OUT_MIN         = -66'sd262144;
   localparam logic signed [18:0] ENTRY_ONE       = 19'sd65536;
   localparam logic signed [18:0] ENTRY_HALF      = 19'sd32768;

   function automatic logic [31:0] atan_q30(input int unsigned i);
      logic [31:0] a;
      case (i)
         0:       a = 32'd843314857;
         1:       a = 32'd497837829;
         2:       a = 32'd263043837;
         3:       a = 32'd133525159;
         4:       a = 32'd67021687;
         5:       a = 32'd33543516;
         6:       a = 32'd16775851;
         7:       a = 32'd8388437;
         8:       a = 32'd4194283;
         9:       a = 32'd2097149;
         10:      a = 32'd1048576;
         11:      a = 32'd524288;
         12:      a = 32'd262144;
         13:      a = 32'd131072;
         14:      a = 32'd65536;
         15:      a = 32'd32768;
         16:      a = 32'd16384;
         17:      a = 32'd8192;
         18:      a = 32'd4096;
         19:      a = 32'd2048;
         20:      a = 32'd1024;
         21:      a = 32'd512;
         22:      a = 32'd256;
         23:      a = 32'd128;
         default: a = 32'd0;
      endcase
      return a;
   endfunction

   // Symmetric saturation of a coefficient to +-2.0 in Q30.
   function automatic logic signed [32:0] clamp_coef(input logic signed [39:0] v);
      logic signed [39:0] r;
      r = v;
      if (v > COEF_LIMIT) begin
         r = COEF_LIMIT;
      end else if (v < -COEF_LIMIT) begin
         r = -COEF_LIMIT;
      end
      return r[32:0];
   endfunction

   // Round half up from Q60 to Q16 and saturate to the output range.
   function automatic logic signed [18:0] round_sat(input logic signed [65:0] v);
      logic signed [65:0] s;
      s = (v + ROUND_Q44) >>> 44;
      if (s > OUT_MAX) begin
         s = OUT_MAX;
      end else if (s < OUT_MIN) begin
         s = OUT_MIN;
      end
      return s[18:0];
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/so3_div_pipe.sv
// Pipelined truncating divider, one quotient bit per stage, with saturation and a side tag.
`default_nettype none

module so3_div_pipe #(
   parameter int DW = 52,
   parameter int NW = 18,
   parameter int QW = 32,
   parameter int TW = 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic signed [DW-1:0] dividend,
   input  wire logic [NW-1:0]        divisor,
   input  wire logic [TW-1:0]        tag_in,
   output logic signed [QW:0]        quotient,
   output logic [TW-1:0]             tag_out
);

   localparam int HW = DW - QW;
   localparam int CW = (HW > NW) ? HW : NW;

   typedef struct packed {
      logic [NW-1:0] rem;
      logic [QW-1:0] lo;
      logic [QW-1:0] q;
      logic          neg;
      logic          ovf;
      logic [NW-1:0] d;
      logic [TW-1:0] tag;
   } dstage_type;

   dstage_type st_in [0:QW];
   dstage_type st_ff [1:QW];
   logic [DW-1:0] mag;
   logic [HW-1:0] hi;
   logic [QW-1:0] qmag;

   always_comb begin
      mag = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
      hi  = mag[DW-1:QW];
      st_in[0].rem = NW'(hi);
      st_in[0].lo  = mag[QW-1:0];
      st_in[0].q   = '0;
      st_in[0].neg = dividend[DW-1];
      // A quotient that needs more than QW bits saturates.
      st_in[0].ovf = (CW'(hi) >= CW'(divisor));
      st_in[0].d   = divisor;
      st_in[0].tag = tag_in;
   end

   for (genvar j = 1; j <= QW; j++) begin : g_step
      logic [NW:0] trial;
      logic        ge;
      dstage_type  prev;
      always_comb begin
         prev  = (j == 1) ? st_in[0] : st_ff[(j == 1) ? 1 : j-1];
         trial = {prev.rem, prev.lo[QW-1]};
         ge    = (trial >= {1'b0, prev.d});
         st_in[j]     = prev;
         st_in[j].rem = ge ? NW'(trial - {1'b0, prev.d}) : NW'(trial);
         st_in[j].lo  = {prev.lo[QW-2:0], 1'b0};
         st_in[j].q   = {prev.q[QW-2:0], ge};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[j] <= '0;
         end else if (en) begin
            st_ff[j] <= st_in[j];
         end
      end
   end

   always_comb begin
      qmag     = st_ff[QW].ovf ? '1 : st_ff[QW].q;
      quotient = st_ff[QW].neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
      tag_out  = st_ff[QW].tag;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/so3_exp_and_jacobians_core.sv
// SO(3) exponential map, left Jacobian and second integral, fully pipelined.
`default_nettype none

// Takes one rotation vector and operation code per cycle and returns one 3x3 Q3.16 matrix
// per cycle while no held output stalls the pipeline. It has one input stage, one
// squaring stage, 19 square-root stages, two range-reduction stages, one CORDIC stage per
// step, one quadrant stage, two 32-stage dividers in a row, and five stages of coefficient
// selection, products, rounding and the output register. The whole pipeline advances only
// when the output register is empty or being read, so req_ready follows rsp_ready. The
// csr word sets the small-angle limit and may be written only while the pipeline is empty.
module so3_exp_and_jacobians_core #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_operation,
   input  wire logic signed [17:0] req_phi_x,
   input  wire logic signed [17:0] req_phi_y,
   input  wire logic signed [17:0] req_phi_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [18:0]      rsp_entry_r0_c0,
   output logic signed [18:0]      rsp_entry_r0_c1,
   output logic signed [18:0]      rsp_entry_r0_c2,
   output logic signed [18:0]      rsp_entry_r1_c0,
   output logic signed [18:0]      rsp_entry_r1_c1,
   output logic signed [18:0]      rsp_entry_r1_c2,
   output logic signed [18:0]      rsp_entry_r2_c0,
   output logic signed [18:0]      rsp_entry_r2_c1,
   output logic signed [18:0]      rsp_entry_r2_c2,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [9:0]         csr_small_angle_limit
);

   import so3_pkg::*;

   localparam int PSH = 30 - ANGLE_FRAC_BITS;
   localparam int PW  = 18 + PSH;
   localparam int DW1 = 52;
   localparam int DW2 = 48;
   localparam int DWU = 48;
   localparam logic signed [32:0] U_MAX = 33'sd1073741824;

   typedef struct packed {
      logic              valid;
      logic [1:0]        op;
      logic signed [17:0] px;
      logic signed [17:0] py;
      logic signed [17:0] pz;
   } front_type;

   typedef struct packed {
      front_type   f;
      logic [36:0] v;
      logic [36:0] res;
   } sq_type;

   typedef struct packed {
      front_type  f;
      logic [17:0] pn;
      logic [3:0]  k;
   } rr_type;

   typedef struct packed {
      front_type          f;
      logic [17:0]        pn;
      logic [1:0]         quad;
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [34:0] z;
   } cd_type;

   typedef struct packed {
      front_type          f;
      logic [17:0]        pn;
      logic signed [33:0] sn;
      logic signed [35:0] omc;
      logic signed [36:0] pms;
   } mp_type;

   typedef struct packed {
      logic               valid;
      logic [1:0]         op;
      logic [17:0]        pn;
      logic signed [33:0] sn;
      logic signed [35:0] omc;
   } d1_tag_type;

   typedef struct packed {
      logic               valid;
      logic [1:0]         op;
      logic [17:0]        pn;
      logic signed [33:0] sn;
      logic signed [35:0] omc;
      logic signed [32:0] ta;
      logic signed [32:0] tb;
      logic signed [32:0] u0;
      logic signed [32:0] u1;
      logic signed [32:0] u2;
   } d2_tag_type;

   typedef struct packed {
      logic               valid;
      logic [1:0]         op;
      logic [17:0]        pn;
      logic signed [32:0] ca;
      logic signed [32:0] cb;
      logic signed [32:0] u0;
      logic signed [32:0] u1;
      logic signed [32:0] u2;
   } jn_type;

   typedef struct packed {
      logic               valid;
      logic [1:0]         op;
      logic [17:0]        pn;
      logic signed [32:0] ca;
      logic signed [32:0] cb;
      logic signed [32:0] u0;
      logic signed [32:0] u1;
      logic signed [32:0] u2;
      logic signed [61:0] s00;
      logic signed [61:0] s11;
      logic signed [61:0] s22;
      logic signed [61:0] s01;
      logic signed [61:0] s02;
      logic signed [61:0] s12;
   } pr1_type;

   typedef struct packed {
      logic               valid;
      logic [1:0]         op;
      logic [17:0]        pn;
      logic signed [32:0] ca;
      logic signed [32:0] cb;
      logic signed [32:0] u0;
      logic signed [32:0] u1;
      logic signed [32:0] u2;
      logic signed [32:0] h00;
      logic signed [32:0] h11;
      logic signed [32:0] h22;
      logic signed [32:0] h01;
      logic signed [32:0] h02;
      logic signed [32:0] h12;
   } h2_type;

   typedef struct packed {
      logic               valid;
      logic [1:0]         op;
      logic [17:0]        pn;
      logic signed [63:0] m0;
      logic signed [63:0] m1;
      logic signed [63:0] m2;
      logic signed [63:0] n00;
      logic signed [63:0] n11;
      logic signed [63:0] n22;
      logic signed [63:0] n01;
      logic signed [63:0] n02;
      logic signed [63:0] n12;
   } pr2_type;

   logic       adv;
   logic [9:0] limit_ff;

   front_type in_ff, in_in;
   sq_type    sq_in [0:19];
   sq_type    sq_ff [0:19];
   rr_type    rr_ff, rr_in;
   cd_type    cd_in [0:CORDIC_STEPS];
   cd_type    cd_ff [0:CORDIC_STEPS];
   mp_type    mp_ff, mp_in;
   jn_type    jn_ff, jn_in;
   pr1_type   pr1_ff, pr1_in;
   h2_type    h2_ff, h2_in;
   pr2_type   pr2_ff, pr2_in;

   logic               rsp_valid_ff;
   logic signed [18:0] rsp_ff [0:8];
   logic signed [18:0] out_in [0:8];

   // The whole pipeline moves together unless a finished word is held at the output.
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 10'd1;
      end else if (csr_valid) begin
         limit_ff <= csr_small_angle_limit;
      end
   end

   // Input stage and sum of squares.
   logic signed [35:0] sqx, sqy, sqz;

   always_comb begin
      in_in.valid = req_valid;
      in_in.op    = req_operation;
      in_in.px    = req_phi_x;
      in_in.py    = req_phi_y;
      in_in.pz    = req_phi_z;
      sqx = in_ff.px * in_ff.px;
      sqy = in_ff.py * in_ff.py;
      sqz = in_ff.pz * in_ff.pz;
      sq_in[0].f   = in_ff;
      sq_in[0].v   = 37'($unsigned(sqx)) + 37'($unsigned(sqy)) + 37'($unsigned(sqz));
      sq_in[0].res = '0;
   end

   // Integer square root, one result bit per stage.
   for (genvar i = 0; i < 19; i++) begin : g_sqrt
      localparam logic [37:0] BITV = 38'd1 << (36 - 2*i);
      logic [37:0] trial;
      always_comb begin
         trial        = {1'b0, sq_ff[i].res} + BITV;
         sq_in[i+1]   = sq_ff[i];
         if ({1'b0, sq_ff[i].v} >= trial) begin
            sq_in[i+1].v   = sq_ff[i].v - trial[36:0];
            sq_in[i+1].res = 37'(({1'b0, sq_ff[i].res} >> 1) + BITV);
         end else begin
            sq_in[i+1].res = sq_ff[i].res >> 1;
         end
      end
   end

   // Range reduction: quadrant count first, then the remainder below pi/2.
   logic [PW-1:0] p_rr;
   logic [PW-1:0] p_cd;
   logic [35:0]   r_cd;

   always_comb begin
      rr_in.f  = sq_ff[19].f;
      rr_in.pn = sq_ff[19].res[17:0];
      p_rr     = PW'(sq_ff[19].res[17:0]) << PSH;
      rr_in.k  = '0;
      for (int j = 1; j <= 8; j++) begin
         if (36'(p_rr) >= 36'(j) * HALF_PI_Q30) begin
            rr_in.k = rr_in.k + 4'd1;
         end
      end
      p_cd          = PW'(rr_ff.pn) << PSH;
      r_cd          = 36'(p_cd) - 36'(rr_ff.k) * HALF_PI_Q30;
      cd_in[0].f    = rr_ff.f;
      cd_in[0].pn   = rr_ff.pn;
      cd_in[0].quad = rr_ff.k[1:0];
      cd_in[0].x    = CORDIC_INV_GAIN;
      cd_in[0].y    = '0;
      cd_in[0].z    = $signed(r_cd[34:0]);
   end

   // Rotation-mode CORDIC, one micro-rotation per stage.
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      logic signed [33:0] dx, dy;
      logic signed [34:0] at;
      always_comb begin
         dx = cd_ff[i].y >>> i;
         dy = cd_ff[i].x >>> i;
         at = $signed(35'(atan_q30(i)));
         cd_in[i+1] = cd_ff[i];
         if (!cd_ff[i].z[34]) begin
            cd_in[i+1].x = cd_ff[i].x - dx;
            cd_in[i+1].y = cd_ff[i].y + dy;
            cd_in[i+1].z = cd_ff[i].z - at;
         end else begin
            cd_in[i+1].x = cd_ff[i].x + dx;
            cd_in[i+1].y = cd_ff[i].y - dy;
            cd_in[i+1].z = cd_ff[i].z + at;
         end
      end
   end

   // Quadrant fold and the two angle terms.
   logic signed [33:0] cs_mp;
   logic [PW-1:0]      p_mp;

   always_comb begin
      mp_in.f  = cd_ff[CORDIC_STEPS].f;
      mp_in.pn = cd_ff[CORDIC_STEPS].pn;
      case (cd_ff[CORDIC_STEPS].quad)
         2'd0: begin
            mp_in.sn = cd_ff[CORDIC_STEPS].y;
            cs_mp    = cd_ff[CORDIC_STEPS].x;
         end
         2'd1: begin
            mp_in.sn = cd_ff[CORDIC_STEPS].x;
            cs_mp    = -cd_ff[CORDIC_STEPS].y;
         end
         2'd2: begin
            mp_in.sn = -cd_ff[CORDIC_STEPS].y;
            cs_mp    = -cd_ff[CORDIC_STEPS].x;
         end
         default: begin
            mp_in.sn = -cd_ff[CORDIC_STEPS].x;
            cs_mp    = cd_ff[CORDIC_STEPS].y;
         end
      endcase
      p_mp      = PW'(cd_ff[CORDIC_STEPS].pn) << PSH;
      mp_in.omc = ONE_Q30 - 36'(cs_mp);
      mp_in.pms = 37'($signed({1'b0, p_mp})) - 37'(mp_in.sn);
   end

   // First division rank: both coefficient numerators and the three unit-axis components.
   logic signed [36:0]    sel_a, sel_b;
   logic signed [DW1-1:0] div1_a, div1_b;
   d1_tag_type            tag1_in, tag1_out;
   logic signed [32:0]    qa1, qb1, qu0, qu1, qu2;

   always_comb begin
      sel_a = (mp_ff.f.op == OP_GAMMA1) ? 37'(mp_ff.omc) : mp_ff.pms;
      sel_b = (mp_ff.f.op == OP_GAMMA1) ? mp_ff.pms : 37'(mp_ff.omc);
      div1_a = DW1'(sel_a) <<< ANGLE_FRAC_BITS;
      div1_b = DW1'(sel_b) <<< ANGLE_FRAC_BITS;
      tag1_in.valid = mp_ff.f.valid;
      tag1_in.op    = mp_ff.f.op;
      tag1_in.pn    = mp_ff.pn;
      tag1_in.sn    = mp_ff.sn;
      tag1_in.omc   = mp_ff.omc;
   end

   so3_div_pipe #(.DW(DW1), .NW(18), .QW(32), .TW($bits(d1_tag_type))) u_div_a1 (
      .clock(clock), .reset(reset), .en(adv), .dividend(div1_a), .divisor(mp_ff.pn),
      .tag_in(tag1_in), .quotient(qa1), .tag_out(tag1_out)
   );
   so3_div_pipe #(.DW(DW1), .NW(18), .QW(32), .TW(1)) u_div_b1 (
      .clock(clock), .reset(reset), .en(adv), .dividend(div1_b), .divisor(mp_ff.pn),
      .tag_in(1'b0), .quotient(qb1), .tag_out()
   );
   so3_div_pipe #(.DW(DWU), .NW(18), .QW(32), .TW(1)) u_div_u0 (
      .clock(clock), .reset(reset), .en(adv), .dividend(DWU'(mp_ff.f.px) <<< 30),
      .divisor(mp_ff.pn), .tag_in(1'b0), .quotient(qu0), .tag_out()
   );
   so3_div_pipe #(.DW(DWU), .NW(18), .QW(32), .TW(1)) u_div_u1 (
      .clock(clock), .reset(reset), .en(adv), .dividend(DWU'(mp_ff.f.py) <<< 30),
      .divisor(mp_ff.pn), .tag_in(1'b0), .quotient(qu1), .tag_out()
   );
   so3_div_pipe #(.DW(DWU), .NW(18), .QW(32), .TW(1)) u_div_u2 (
      .clock(clock), .reset(reset), .en(adv), .dividend(DWU'(mp_ff.f.pz) <<< 30),
      .divisor(mp_ff.pn), .tag_in(1'b0), .quotient(qu2), .tag_out()
   );

   // Second division rank, used by the second integral only.
   d2_tag_type            tag2_in, tag2_out;
   logic signed [DW2-1:0] div2_a, div2_b;
   logic signed [32:0]    qa2, qb2;

   always_comb begin
      tag2_in.valid = tag1_out.valid;
      tag2_in.op    = tag1_out.op;
      tag2_in.pn    = tag1_out.pn;
      tag2_in.sn    = tag1_out.sn;
      tag2_in.omc   = tag1_out.omc;
      tag2_in.ta    = clamp_coef(40'(qa1));
      tag2_in.tb    = clamp_coef(40'(qb1));
      tag2_in.u0    = qu0;
      tag2_in.u1    = qu1;
      tag2_in.u2    = qu2;
      div2_a = DW2'(tag2_in.ta) <<< ANGLE_FRAC_BITS;
      div2_b = DW2'(tag2_in.tb) <<< ANGLE_FRAC_BITS;
   end

   so3_div_pipe #(.DW(DW2), .NW(18), .QW(32), .TW($bits(d2_tag_type))) u_div_a2 (
      .clock(clock), .reset(reset), .en(adv), .dividend(div2_a), .divisor(tag1_out.pn),
      .tag_in(tag2_in), .quotient(qa2), .tag_out(tag2_out)
   );
   so3_div_pipe #(.DW(DW2), .NW(18), .QW(32), .TW(1)) u_div_b2 (
      .clock(clock), .reset(reset), .en(adv), .dividend(div2_b), .divisor(tag1_out.pn),
      .tag_in(1'b0), .quotient(qb2), .tag_out()
   );

   // Coefficient selection per operation.
   always_comb begin
      jn_in.valid = tag2_out.valid;
      jn_in.op    = tag2_out.op;
      jn_in.pn    = tag2_out.pn;
      jn_in.u0    = tag2_out.u0;
      jn_in.u1    = tag2_out.u1;
      jn_in.u2    = tag2_out.u2;
      case (tag2_out.op)
         OP_EXP: begin
            jn_in.ca = clamp_coef(40'(tag2_out.sn));
            jn_in.cb = clamp_coef(40'(tag2_out.omc));
         end
         OP_GAMMA1: begin
            jn_in.ca = tag2_out.ta;
            jn_in.cb = tag2_out.tb;
         end
         OP_GAMMA2: begin
            jn_in.ca = clamp_coef(40'(qa2));
            jn_in.cb = clamp_coef(COEF_HALF - 40'(qb2));
         end
         default: begin
            jn_in.ca = '0;
            jn_in.cb = '0;
         end
      endcase
   end

   // Outer products of the unit axis.
   logic signed [65:0] w00, w11, w22, w01, w02, w12;

   always_comb begin
      w00 = jn_ff.u0 * jn_ff.u0;
      w11 = jn_ff.u1 * jn_ff.u1;
      w22 = jn_ff.u2 * jn_ff.u2;
      w01 = jn_ff.u0 * jn_ff.u1;
      w02 = jn_ff.u0 * jn_ff.u2;
      w12 = jn_ff.u1 * jn_ff.u2;
      pr1_in.valid = jn_ff.valid;
      pr1_in.op    = jn_ff.op;
      pr1_in.pn    = jn_ff.pn;
      pr1_in.ca    = jn_ff.ca;
      pr1_in.cb    = jn_ff.cb;
      pr1_in.u0    = jn_ff.u0;
      pr1_in.u1    = jn_ff.u1;
      pr1_in.u2    = jn_ff.u2;
      pr1_in.s00   = w00[61:0];
      pr1_in.s11   = w11[61:0];
      pr1_in.s22   = w22[61:0];
      pr1_in.s01   = w01[61:0];
      pr1_in.s02   = w02[61:0];
      pr1_in.s12   = w12[61:0];
   end

   // Squared skew matrix back in Q30; it is symmetric with the diagonal -(|u|^2 - u_i^2).
   logic signed [62:0] t00, t11, t22;

   always_comb begin
      t00 = -(63'(pr1_ff.s11) + 63'(pr1_ff.s22));
      t11 = -(63'(pr1_ff.s00) + 63'(pr1_ff.s22));
      t22 = -(63'(pr1_ff.s00) + 63'(pr1_ff.s11));
      h2_in.valid = pr1_ff.valid;
      h2_in.op    = pr1_ff.op;
      h2_in.pn    = pr1_ff.pn;
      h2_in.ca    = pr1_ff.ca;
      h2_in.cb    = pr1_ff.cb;
      h2_in.u0    = pr1_ff.u0;
      h2_in.u1    = pr1_ff.u1;
      h2_in.u2    = pr1_ff.u2;
      h2_in.h00   = 33'(t00 >>> 30);
      h2_in.h11   = 33'(t11 >>> 30);
      h2_in.h22   = 33'(t22 >>> 30);
      h2_in.h01   = 33'(pr1_ff.s01 >>> 30);
      h2_in.h02   = 33'(pr1_ff.s02 >>> 30);
      h2_in.h12   = 33'(pr1_ff.s12 >>> 30);
   end

   // Coefficient products.
   logic signed [65:0] x0, x1, x2, y00, y11, y22, y01, y02, y12;

   always_comb begin
      x0  = h2_ff.ca * h2_ff.u0;
      x1  = h2_ff.ca * h2_ff.u1;
      x2  = h2_ff.ca * h2_ff.u2;
      y00 = h2_ff.cb * h2_ff.h00;
      y11 = h2_ff.cb * h2_ff.h11;
      y22 = h2_ff.cb * h2_ff.h22;
      y01 = h2_ff.cb * h2_ff.h01;
      y02 = h2_ff.cb * h2_ff.h02;
      y12 = h2_ff.cb * h2_ff.h12;
      pr2_in.valid = h2_ff.valid;
      pr2_in.op    = h2_ff.op;
      pr2_in.pn    = h2_ff.pn;
      pr2_in.m0    = x0[63:0];
      pr2_in.m1    = x1[63:0];
      pr2_in.m2    = x2[63:0];
      pr2_in.n00   = y00[63:0];
      pr2_in.n11   = y11[63:0];
      pr2_in.n22   = y22[63:0];
      pr2_in.n01   = y01[63:0];
      pr2_in.n02   = y02[63:0];
      pr2_in.n12   = y12[63:0];
   end

   // Final sums, rounding and the small-angle and unused-code overrides.
   logic signed [65:0] diag;
   logic signed [65:0] m0w, m1w, m2w;
   logic               near_zero;

   always_comb begin
      diag  = (pr2_ff.op == OP_GAMMA2) ? DIAG_HALF_Q60 : DIAG_ONE_Q60;
      m0w   = 66'(pr2_ff.m0);
      m1w   = 66'(pr2_ff.m1);
      m2w   = 66'(pr2_ff.m2);
      near_zero = (pr2_ff.pn == '0) || (pr2_ff.pn < {8'd0, limit_ff});
      out_in[0] = round_sat(66'(pr2_ff.n00) + diag);
      out_in[1] = round_sat(66'(pr2_ff.n01) - m2w);
      out_in[2] = round_sat(66'(pr2_ff.n02) + m1w);
      out_in[3] = round_sat(66'(pr2_ff.n01) + m2w);
      out_in[4] = round_sat(66'(pr2_ff.n11) + diag);
      out_in[5] = round_sat(66'(pr2_ff.n12) - m0w);
      out_in[6] = round_sat(66'(pr2_ff.n02) - m1w);
      out_in[7] = round_sat(66'(pr2_ff.n12) + m0w);
      out_in[8] = round_sat(66'(pr2_ff.n22) + diag);
      if (pr2_ff.op == OP_NONE) begin
         for (int e = 0; e < 9; e++) begin
            out_in[e] = '0;
         end
      end else if (near_zero) begin
         for (int e = 0; e < 9; e++) begin
            out_in[e] = '0;
         end
         out_in[0] = (pr2_ff.op == OP_GAMMA2) ? ENTRY_HALF : ENTRY_ONE;
         out_in[4] = out_in[0];
         out_in[8] = out_in[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ff        <= '0;
         rr_ff        <= '0;
         mp_ff        <= '0;
         jn_ff        <= '0;
         pr1_ff       <= '0;
         h2_ff        <= '0;
         pr2_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < 20; s++) begin
            sq_ff[s] <= '0;
         end
         for (int s = 0; s <= CORDIC_STEPS; s++) begin
            cd_ff[s] <= '0;
         end
         for (int e = 0; e < 9; e++) begin
            rsp_ff[e] <= '0;
         end
      end else if (adv) begin
         in_ff        <= in_in;
         rr_ff        <= rr_in;
         mp_ff        <= mp_in;
         jn_ff        <= jn_in;
         pr1_ff       <= pr1_in;
         h2_ff        <= h2_in;
         pr2_ff       <= pr2_in;
         rsp_valid_ff <= pr2_ff.valid;
         for (int s = 0; s < 20; s++) begin
            sq_ff[s] <= sq_in[s];
         end
         for (int s = 0; s <= CORDIC_STEPS; s++) begin
            cd_ff[s] <= cd_in[s];
         end
         for (int e = 0; e < 9; e++) begin
            rsp_ff[e] <= out_in[e];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_r0_c0 = rsp_ff[0];
   assign rsp_entry_r0_c1 = rsp_ff[1];
   assign rsp_entry_r0_c2 = rsp_ff[2];
   assign rsp_entry_r1_c0 = rsp_ff[3];
   assign rsp_entry_r1_c1 = rsp_ff[4];
   assign rsp_entry_r1_c2 = rsp_ff[5];
   assign rsp_entry_r2_c0 = rsp_ff[6];
   assign rsp_entry_r2_c1 = rsp_ff[7];
   assign rsp_entry_r2_c2 = rsp_ff[8];

   // The norm of an 18-bit vector always fits in 18 bits.
   a_norm_width: assert property (@(posedge clock) disable iff (reset)
      sq_ff[19].f.valid |-> (sq_ff[19].res[36:18] == '0))
      else $error("square root result exceeds 18 bits");

   // The reduced angle handed to the CORDIC lies in [0, pi/2).
   a_reduced_angle: assert property (@(posedge clock) disable iff (reset)
      cd_ff[0].f.valid |-> (!cd_ff[0].z[34] && ($unsigned(cd_ff[0].z) < 35'(HALF_PI_Q30))))
      else $error("range reduction out of bounds");

   // Each unit-axis component stays within +-1.0 in Q30; a zero norm has no axis.
   a_unit_axis: assert property (@(posedge clock) disable iff (reset)
      (jn_ff.valid && (jn_ff.pn != '0)) |->
         (jn_ff.u0 <= U_MAX && jn_ff.u0 >= -U_MAX &&
          jn_ff.u1 <= U_MAX && jn_ff.u1 >= -U_MAX &&
          jn_ff.u2 <= U_MAX && jn_ff.u2 >= -U_MAX))
      else $error("unit axis component out of range");

endmodule

`default_nettype wire
